/* rtl/core/rrid_pkg.sv */
`default_nettype none

package rrid_pkg;

    // Table size used when the top level is not given another.
    localparam int ENTRIES_DEF = 16;

    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 32;

    // Input transfer payload: func, key, handle, padded to whole bytes.
    localparam int IN_BITS   = FUNC_W + KEY_W + HANDLE_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = HANDLE_W;

    localparam int KEY_LSB    = FUNC_W;
    localparam int HANDLE_LSB = FUNC_W + KEY_W;

    typedef logic [FUNC_W-1:0] func_t;

    localparam func_t FUNC_LOOKUP = 2'd0;
    localparam func_t FUNC_ADD    = 2'd1;
    localparam func_t FUNC_DELETE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // latch operands and restart the scan
        logic scan;      // walk the table one entry per cycle
        logic del_en;    // clear entries whose handle matches
        logic write;     // store the latched pair at the next slot
        logic out_load;  // move the lookup answer into the output register
    } rrid_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cmp_valid;   // a table entry is at the compare stage
        logic key_hit;     // that entry's key matches
        logic last_entry;  // that entry is the last one in the table
        logic out_free;    // the output register can take a result
    } rrid_sts_t;

endpackage

`default_nettype wire

/* rtl/core/rrid_ram.sv */
`default_nettype none

module rrid_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/rrid_ctrl.sv */
`default_nettype none

module rrid_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire rrid_pkg::func_t    func,
    output      logic               in_ready,
    input  wire rrid_pkg::rrid_sts_t sts,
    output      rrid_pkg::rrid_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_WRITE  = 5'b00010,
        ST_LOOKUP = 5'b00100,
        ST_DELETE = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    unique case (func)
                        rrid_pkg::FUNC_LOOKUP: state_next = ST_LOOKUP;
                        rrid_pkg::FUNC_ADD:    state_next = ST_WRITE;
                        rrid_pkg::FUNC_DELETE: state_next = ST_DELETE;
                        default:               state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_LOOKUP:
            begin
                cmd.scan = 1'b1;
                // The first matching entry ends the scan; lower indexes win.
                if (sts.cmp_valid && (sts.key_hit || sts.last_entry))
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_DELETE:
            begin
                cmd.scan   = 1'b1;
                cmd.del_en = 1'b1;
                if (sts.cmp_valid && sts.last_entry)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/rrid_datapath.sv */
`default_nettype none

module rrid_datapath #(
    parameter int ENTRIES = rrid_pkg::ENTRIES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [rrid_pkg::KEY_W-1:0]      key,
    input  wire logic [rrid_pkg::HANDLE_W-1:0]   handle,
    input  wire rrid_pkg::rrid_cmd_t             cmd,
    output      rrid_pkg::rrid_sts_t             sts,
    input  wire logic                            out_ready,
    output      logic                            out_valid,
    output      logic [rrid_pkg::HANDLE_W-1:0]   found_handle
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int WORD_W = rrid_pkg::KEY_W + rrid_pkg::HANDLE_W;

    logic [rrid_pkg::KEY_W-1:0]    key_op_reg;
    logic [rrid_pkg::HANDLE_W-1:0] handle_op_reg;

    logic [IDX_W-1:0] wpos_reg;
    logic [IDX_W-1:0] wpos_next;
    logic [ENTRIES-1:0] valid_reg;

    logic [CNT_W-1:0] rd_cnt_reg;
    logic             issue;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;

    logic [WORD_W-1:0]             ram_q;
    logic [rrid_pkg::KEY_W-1:0]    ent_key;
    logic [rrid_pkg::HANDLE_W-1:0] ent_handle;
    logic                          key_hit;
    logic                          handle_hit;

    logic [rrid_pkg::HANDLE_W-1:0] result_reg;
    logic                          out_valid_reg;
    logic [rrid_pkg::HANDLE_W-1:0] out_data_reg;

    rrid_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (wpos_next),
        .wdata ({handle_op_reg, key_op_reg}),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (ram_q)
    );

    // The write position advances before the pair is stored.
    assign wpos_next = (wpos_reg == IDX_W'(ENTRIES - 1)) ? '0 : wpos_reg + 1'b1;

    assign issue = cmd.scan && (rd_cnt_reg != CNT_W'(ENTRIES));

    // An entry never written since reset or cleared by a delete reads as zeros.
    assign ent_key    = valid_reg[cmp_idx_reg] ? ram_q[rrid_pkg::KEY_W-1:0] : '0;
    assign ent_handle = valid_reg[cmp_idx_reg] ? ram_q[WORD_W-1:rrid_pkg::KEY_W] : '0;
    assign key_hit    = (ent_key == key_op_reg);
    assign handle_hit = (ent_handle == handle_op_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_op_reg    <= key;
            handle_op_reg <= handle;
        end
        // Only compares made during the scan itself update the answer, so a
        // read still in flight when the scan stops cannot overwrite it.
        if (cmd.scan && cmp_vld_reg)
        begin
            result_reg <= key_hit ? ent_handle : '0;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= result_reg;
        end
        cmp_idx_reg <= rd_cnt_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg      <= '0;
            valid_reg     <= '0;
            rd_cnt_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                rd_cnt_reg <= '0;
            end
            else if (issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
            cmp_vld_reg <= issue;

            if (cmd.write)
            begin
                wpos_reg             <= wpos_next;
                valid_reg[wpos_next] <= 1'b1;
            end
            else if (cmd.del_en && cmp_vld_reg && handle_hit)
            begin
                valid_reg[cmp_idx_reg] <= 1'b0;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts            = '0;
        sts.cmp_valid  = cmp_vld_reg;
        sts.key_hit    = key_hit;
        sts.last_entry = (cmp_idx_reg == IDX_W'(ENTRIES - 1));
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign found_handle = out_data_reg;

endmodule

`default_nettype wire

/* rtl/core/round_robin_id_lookup_cache_unit.sv */
`default_nettype none

// Channel   Direction  Payload
// s_*       in         tdata: func[1:0], key[33:2], handle[65:34], zero pad[71:66]
// m_*       out        tdata: found_handle[31:0]
//
// An add is accepted and then stored in the table write state. A lookup or
// a delete walks the table one entry per cycle through the registered read
// port of the table memory; a delete always walks the whole table, a lookup
// stops early when the key matches. Reset clears the table at once through
// per-entry valid bits, so no clearing pass is needed. A finished lookup
// answer waits in the output register while the next item is accepted; a
// lookup that finishes while that register is still full stalls until the
// earlier answer has been taken.

module round_robin_id_lookup_cache_unit #(
    parameter int ENTRIES = rrid_pkg::ENTRIES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // func[1:0], key[33:2], handle[65:34], zeros above
    input  wire logic [rrid_pkg::IN_DATA_W-1:0]  s_tdata,
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // found_handle[31:0]
    output      logic [rrid_pkg::OUT_DATA_W-1:0] m_tdata
);

    rrid_pkg::rrid_cmd_t cmd;
    rrid_pkg::rrid_sts_t sts;
    rrid_pkg::func_t     func;

    assign func = s_tdata[rrid_pkg::FUNC_W-1:0];

    rrid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .func     (func),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rrid_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .key          (s_tdata[rrid_pkg::KEY_LSB +: rrid_pkg::KEY_W]),
        .handle       (s_tdata[rrid_pkg::HANDLE_LSB +: rrid_pkg::HANDLE_W]),
        .cmd          (cmd),
        .sts          (sts),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .found_handle (m_tdata)
    );

    // A lookup answer never overwrites one that has not been taken.
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("lookup answer loaded over a pending transfer");

    // A new output transfer only appears after a lookup has finished.
    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.out_load))
        else $error("output transfer without a finished lookup");

    // Any valid operation keeps the input side closed on the next cycle.
    a_busy_after_op: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (func == rrid_pkg::FUNC_LOOKUP ||
         func == rrid_pkg::FUNC_ADD || func == rrid_pkg::FUNC_DELETE))
        |=> !s_tready)
        else $error("input accepted while an operation is in progress");

endmodule

`default_nettype wire

/* verif/round_robin_id_lookup_cache_unit_tb.sv */
`timescale 1ns / 100ps

module round_robin_id_lookup_cache_unit_tb;

    localparam int ENTRIES     = rrid_pkg::ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 2 * ENTRIES + 8;
    localparam int PHASE_ITEMS = 250;
    localparam int POOL_SIZE   = 8;

    // The fourth code has no meaning in the block and must be ignored.
    localparam rrid_pkg::func_t FUNC_UNUSED = 2'd3;

    // Pacing styles for the source gaps and the sink stalls.
    localparam int PACE_NONE  = 0;
    localparam int PACE_MIXED = 1;
    localparam int PACE_HEAVY = 2;

    typedef struct packed {
        logic [rrid_pkg::HANDLE_W-1:0] handle;
        logic [rrid_pkg::KEY_W-1:0]    key;
        rrid_pkg::func_t               func;
    } cache_req_t;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [rrid_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [rrid_pkg::OUT_DATA_W-1:0] m_tdata;

    // Mirror of the table contents and the write slot.
    logic [rrid_pkg::KEY_W-1:0]    cache_keys    [ENTRIES];
    logic [rrid_pkg::HANDLE_W-1:0] cache_handles [ENTRIES];
    int                            cache_wr_slot;

    cache_req_t                    pending_reqs[$];
    logic [rrid_pkg::HANDLE_W-1:0] expected_handles[$];

    logic [rrid_pkg::KEY_W-1:0]    key_pool    [POOL_SIZE];
    logic [rrid_pkg::HANDLE_W-1:0] handle_pool [POOL_SIZE];

    int reqs_issued   = 0;
    int reqs_accepted = 0;
    int err_count     = 0;
    int cycle_count   = 0;
    int pace_mode     = PACE_MIXED;
    int src_gap       = 0;
    int sink_gap      = 0;
    logic [rrid_pkg::HANDLE_W-1:0] want_handle;

    round_robin_id_lookup_cache_unit #(
        .ENTRIES(ENTRIES)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int pick_gap(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == PACE_NONE)
            return 0;
        if (mode == PACE_MIXED)
        begin
            if (r < 60)
                return 0;
            if (r < 90)
                return $urandom_range(1, 3);
            return $urandom_range(4, 40);
        end
        if (r < 30)
            return 0;
        if (r < 85)
            return $urandom_range(1, 6);
        return $urandom_range(10, 60);
    endfunction

    // Updates the mirrored table for one accepted request and queues the
    // answer of a lookup.
    task automatic apply_request(input cache_req_t req);
        logic [rrid_pkg::HANDLE_W-1:0] found;
        logic                          hit;
        found = '0;
        hit   = 1'b0;
        case (req.func)
            rrid_pkg::FUNC_LOOKUP:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!hit && cache_keys[i] == req.key)
                    begin
                        found = cache_handles[i];
                        hit   = 1'b1;
                    end
                end
                expected_handles.push_back(found);
            end
            rrid_pkg::FUNC_ADD:
            begin
                cache_wr_slot = (cache_wr_slot == ENTRIES - 1) ? 0 : cache_wr_slot + 1;
                cache_keys[cache_wr_slot]    = req.key;
                cache_handles[cache_wr_slot] = req.handle;
            end
            rrid_pkg::FUNC_DELETE:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (cache_handles[i] == req.handle)
                    begin
                        cache_keys[i]    = '0;
                        cache_handles[i] = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic push_req(input rrid_pkg::func_t func,
                            input logic [rrid_pkg::KEY_W-1:0] key,
                            input logic [rrid_pkg::HANDLE_W-1:0] handle);
        cache_req_t req;
        req.func   = func;
        req.key    = key;
        req.handle = handle;
        pending_reqs.push_back(req);
        reqs_issued++;
    endtask

    function automatic logic [rrid_pkg::KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 92)
            return $urandom();
        return '0;
    endfunction

    function automatic logic [rrid_pkg::HANDLE_W-1:0] pick_handle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return handle_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 92)
            return $urandom();
        return '0;
    endfunction

    task automatic wait_idle();
        while (reqs_accepted != reqs_issued || expected_handles.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Source side: one transfer per queued request, taken from the queue only
    // when the bus is free, with random gaps between transfers.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_request(cache_req_t'(s_tdata[rrid_pkg::IN_BITS-1:0]));
                reqs_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(rrid_pkg::IN_DATA_W - rrid_pkg::IN_BITS){1'b0}},
                                 pending_reqs.pop_front()};
                    src_gap = pick_gap(pace_mode);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: checks each result transfer against the oldest expected answer.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_handles.size() == 0)
                begin
                    $display("%0t: result with none expected: found_handle actual %h",
                             $time, m_tdata);
                    err_count++;
                end
                else
                begin
                    want_handle = expected_handles.pop_front();
                    if (m_tdata !== want_handle)
                    begin
                        $display("%0t: found_handle mismatch: expected %h, actual %h",
                                 $time, want_handle, m_tdata);
                        err_count++;
                    end
                end
                sink_gap = pick_gap(pace_mode);
            end
            else if (pace_mode != PACE_NONE && sink_gap == 0 && $urandom_range(0, 99) < 5)
            begin
                sink_gap = pick_gap(pace_mode);
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        int r;
        int mode_seq[3];
        for (int i = 0; i < ENTRIES; i++)
        begin
            cache_keys[i]    = '0;
            cache_handles[i] = '0;
        end
        cache_wr_slot = 0;
        mode_seq[0] = PACE_MIXED;
        mode_seq[1] = PACE_NONE;
        mode_seq[2] = PACE_HEAVY;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Lookups on a cleared table: key zero hits the cleared slots.
        push_req(rrid_pkg::FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        push_req(rrid_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Key zero stored in slot 1 loses to cleared slot 0.
        push_req(rrid_pkg::FUNC_ADD,    32'h0000_0000, 32'hFFFF_FFFF);
        push_req(rrid_pkg::FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        // Duplicate keys: the lower slot answers.
        push_req(rrid_pkg::FUNC_ADD,    32'hA5A5_5A5A, 32'h0000_1234);
        push_req(rrid_pkg::FUNC_ADD,    32'hA5A5_5A5A, 32'h0000_5678);
        push_req(rrid_pkg::FUNC_LOOKUP, 32'hA5A5_5A5A, 32'h0000_0000);
        push_req(rrid_pkg::FUNC_DELETE, 32'h0000_0000, 32'h0000_1234);
        push_req(rrid_pkg::FUNC_LOOKUP, 32'hA5A5_5A5A, 32'h0000_0000);
        // Deleting handle zero also removes a key that was stored with it.
        push_req(rrid_pkg::FUNC_ADD,    32'h0000_0077, 32'h0000_0000);
        push_req(rrid_pkg::FUNC_LOOKUP, 32'h0000_0077, 32'h0000_0000);
        push_req(rrid_pkg::FUNC_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
        push_req(rrid_pkg::FUNC_LOOKUP, 32'h0000_0077, 32'h0000_0000);
        // The unused code must leave the table untouched.
        push_req(FUNC_UNUSED,           32'h5A5A_A5A5, 32'hFFFF_FFFF);
        push_req(FUNC_UNUSED,           32'hA5A5_5A5A, 32'h0000_5678);
        push_req(rrid_pkg::FUNC_LOOKUP, 32'hA5A5_5A5A, 32'h0000_0000);
        push_req(rrid_pkg::FUNC_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(rrid_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        push_req(rrid_pkg::FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        push_req(rrid_pkg::FUNC_DELETE, 32'h0000_0000, 32'hFFFF_FFFF);
        push_req(rrid_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        push_req(rrid_pkg::FUNC_DELETE, 32'h0000_0000, 32'hDEAD_BEEF);
        push_req(rrid_pkg::FUNC_LOOKUP, 32'hA5A5_5A5A, 32'h0000_0000);
        wait_idle();

        // Small key and handle pools keep lookups and deletes hitting while
        // the write slot wraps many times; fresh pools for every phase.
        for (int p = 0; p < 3; p++)
        begin
            pace_mode = mode_seq[p];
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                key_pool[i]    = $urandom();
                handle_pool[i] = $urandom();
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < 4)
                    push_req(FUNC_UNUSED, $urandom(), $urandom());
                r = $urandom_range(0, 99);
                if (r < 42)
                    push_req(rrid_pkg::FUNC_ADD, pick_key(), pick_handle());
                else if (r < 85)
                    push_req(rrid_pkg::FUNC_LOOKUP, pick_key(), $urandom());
                else
                    push_req(rrid_pkg::FUNC_DELETE, $urandom(), pick_handle());
            end
            wait_idle();
        end

        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/core/rrid_pkg.sv
rtl/core/rrid_ram.sv
rtl/core/rrid_ctrl.sv
rtl/core/rrid_datapath.sv
rtl/core/round_robin_id_lookup_cache_unit.sv
verif/round_robin_id_lookup_cache_unit_tb.sv
